[rtl/smb_pkg.sv]
// Shared constants, types and helpers for the substring match bracketer.
package smb_pkg;

   localparam int MAX_PATTERN = 8;
   localparam int MAX_RESULTS = MAX_PATTERN + 3;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 4;
   localparam int SEQ_IDX_W   = $clog2(MAX_PATTERN + 1);
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 64;

   // register indexes on the configuration channel
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_BYTES  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH = CSR_IDX_W'(1);

   localparam logic [BYTE_W-1:0] OPEN_PAREN  = 8'h28;
   localparam logic [BYTE_W-1:0] CLOSE_PAREN = 8'h29;

   localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(1);

   // held bytes plus the incoming one, oldest first
   typedef logic [MAX_PATTERN:0][BYTE_W-1:0] seq_type;
   typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_type;

   // all result beats caused by one item
   typedef struct packed {
      logic [MAX_RESULTS-1:0][BYTE_W-1:0] data;
      logic [RES_CNT_W-1:0]               count;
      logic                               last;
   } burst_type;

   // length in use: zero acts as one, anything above the window as the window
   function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] res;
      res = len;
      if (len == '0) begin
         res = LEN_W'(1);
      end else if (len > LEN_W'(MAX_PATTERN)) begin
         res = LEN_W'(MAX_PATTERN);
      end
      return res;
   endfunction

endpackage

[rtl/smb_if.sv]
// Channel interfaces: text input, result output and register write.
interface smb_req_if;
   import smb_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              text_end;
   modport source (output valid, output text_byte, output text_end, input ready);
   modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

interface smb_rsp_if;
   import smb_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              out_end;
   modport source (output valid, output out_byte, output out_end, input ready);
   modport sink   (input valid, input out_byte, input out_end, output ready);
endinterface

interface smb_csr_if;
   import smb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  wr_index;
   logic [CSR_DATA_W-1:0] wr_data;
   modport source (output valid, output wr_index, output wr_data, input ready);
   modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

[rtl/smb_core.sv]
// Match window: held bytes, pattern compare and the result list of one item.
module smb_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  logic [smb_pkg::BYTE_W-1:0]    item_byte,
   input  logic                          item_end,
   input  logic [smb_pkg::CSR_DATA_W-1:0] pattern_bytes,
   input  logic [smb_pkg::LEN_W-1:0]     pattern_length,
   output smb_pkg::burst_type            burst
);
   import smb_pkg::*;

   window_type         held_ff;
   logic [LEN_W-1:0]   held_count_ff;
   logic [LEN_W-1:0]   held_count_in;

   seq_type            seq;
   window_type         win;
   logic [LEN_W-1:0]   len;
   logic [LEN_W-1:0]   drop;
   logic               full;
   logic               same;
   logic               match;

   function automatic logic [BYTE_W-1:0] seq_at(input seq_type s,
                                                input logic [LEN_W:0] idx);
      logic [BYTE_W-1:0] res;
      res = '0;
      if (idx <= (LEN_W+1)'(MAX_PATTERN)) begin
         res = s[idx[SEQ_IDX_W-1:0]];
      end
      return res;
   endfunction

   always_comb begin
      logic [LEN_W:0] idx;
      logic [LEN_W:0] kk;
      logic [LEN_W:0] c_ext;
      len = eff_length(pattern_length);
      c_ext = {1'b0, held_count_ff};

      // the incoming byte lands just above the held ones
      for (int i = 0; i < MAX_PATTERN; i++) begin
         seq[i] = (LEN_W'(i) == held_count_ff) ? item_byte : held_ff[i];
      end
      seq[MAX_PATTERN] = item_byte;

      drop = (held_count_ff >= len) ? (held_count_ff - len + LEN_W'(1)) : '0;
      full = ((c_ext + (LEN_W+1)'(1)) >= {1'b0, len});

      for (int i = 0; i < MAX_PATTERN; i++) begin
         idx    = {1'b0, drop} + (LEN_W+1)'(i);
         win[i] = seq_at(seq, idx);
      end

      same = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if ((LEN_W'(i) < len) && (win[i] != pattern_bytes[i*BYTE_W +: BYTE_W])) begin
            same = 1'b0;
         end
      end
      match = full && same;

      // with a match, '(' goes in at the drop point and ')' follows the window
      for (int k = 0; k < MAX_RESULTS; k++) begin
         kk = (LEN_W+1)'(k);
         if (!match) begin
            burst.data[k] = seq_at(seq, kk);
         end else if (kk < {1'b0, drop}) begin
            burst.data[k] = seq_at(seq, kk);
         end else if (kk == {1'b0, drop}) begin
            burst.data[k] = OPEN_PAREN;
         end else if (kk <= c_ext + (LEN_W+1)'(1)) begin
            burst.data[k] = seq_at(seq, kk - (LEN_W+1)'(1));
         end else begin
            burst.data[k] = CLOSE_PAREN;
         end
      end

      priority if (match) begin
         burst.count = RES_CNT_W'(c_ext) + RES_CNT_W'(3);
      end else if (item_end) begin
         burst.count = RES_CNT_W'(c_ext) + RES_CNT_W'(1);
      end else begin
         burst.count = RES_CNT_W'(drop);
      end
      burst.last = item_end;

      if (match || item_end) begin
         held_count_in = '0;
      end else begin
         held_count_in = held_count_ff + LEN_W'(1) - drop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
      end else if (item_valid) begin
         held_count_ff <= held_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid) begin
         held_ff <= win;
      end
   end

endmodule

[rtl/substring_match_bracketer_unit.sv]
// Top level of the substring match bracketer: channels, staging and beat output.
//
// Text comes in one byte a beat on req_bus; text_end marks the final byte.
// Every leftmost, non-overlapping occurrence of the pattern is sent out on
// rsp_bus wrapped in '(' and ')'; all other bytes pass through in order.
// Bytes are held back up to the pattern length, so output trails input.
// The pattern (register 0, first char in the low byte) and its length
// (register 1, 1 to 8) are written over csr_bus, which is always ready;
// write them only while no text is in flight.
// An item passes the input register, then the result list register, then
// the output register, before its first result beat is on rsp_bus.
// Throughput: one item a cycle while each item gives at most one result
// beat and the receiver keeps up; an item giving more beats holds the input
// side until the output register has drained its result list, which it
// does one beat a cycle while rsp_bus.ready is high.
// Reset clears the held window, the stages and the registers (length 1).
// When the receiver stalls, the output register holds its beat, an empty
// result list still takes one more item and the input register another,
// then req_bus.ready drops.
module substring_match_bracketer_unit (
   input  logic       clock,
   input  logic       reset,
   smb_req_if.sink    req_bus,
   smb_rsp_if.source  rsp_bus,
   smb_csr_if.sink    csr_bus
);
   import smb_pkg::*;

   // configuration
   logic [CSR_DATA_W-1:0] pattern_bytes_ff;
   logic [LEN_W-1:0]      pattern_length_ff;

   // input register
   logic                  in_valid_ff;
   logic [BYTE_W-1:0]     in_byte_ff;
   logic                  in_end_ff;

   // result list register
   logic [MAX_RESULTS-1:0][BYTE_W-1:0] burst_data_ff;
   logic [MAX_RESULTS-1:0][BYTE_W-1:0] burst_data_in;
   logic [RES_CNT_W-1:0]  burst_count_ff;
   logic [RES_CNT_W-1:0]  burst_count_in;
   logic                  burst_last_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [BYTE_W-1:0]     rsp_byte_ff;
   logic                  rsp_end_ff;

   burst_type             core_burst;
   logic                  req_take;
   logic                  shift;
   logic                  list_free;
   logic                  move;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff  <= '0;
         pattern_length_ff <= LENGTH_RESET;
      end else if (csr_bus.valid) begin
         if (csr_bus.wr_index == REG_PATTERN_BYTES) begin
            pattern_bytes_ff <= csr_bus.wr_data;
         end
         if (csr_bus.wr_index == REG_PATTERN_LENGTH) begin
            pattern_length_ff <= csr_bus.wr_data[LEN_W-1:0];
         end
      end
   end

   // a beat leaves the list when the output register is empty or draining
   assign shift     = (burst_count_ff != '0) && (!rsp_valid_ff || rsp_bus.ready);
   // the list takes a new item once it is empty or on its last beat out
   assign list_free = (burst_count_ff == '0) ||
                      ((burst_count_ff == RES_CNT_W'(1)) && shift);
   assign move      = in_valid_ff && list_free;

   assign req_bus.ready = !in_valid_ff || move;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (move) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_bus.text_byte;
         in_end_ff  <= req_bus.text_end;
      end
   end

   smb_core u_core (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (move),
      .item_byte      (in_byte_ff),
      .item_end       (in_end_ff),
      .pattern_bytes  (pattern_bytes_ff),
      .pattern_length (pattern_length_ff),
      .burst          (core_burst)
   );

   always_comb begin
      burst_data_in  = burst_data_ff;
      burst_count_in = burst_count_ff;
      if (move) begin
         burst_data_in  = core_burst.data;
         burst_count_in = core_burst.count;
      end else if (shift) begin
         for (int j = 0; j < MAX_RESULTS - 1; j++) begin
            burst_data_in[j] = burst_data_ff[j+1];
         end
         burst_data_in[MAX_RESULTS-1] = '0;
         burst_count_in = burst_count_ff - RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_count_ff <= '0;
      end else begin
         burst_count_ff <= burst_count_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_data_ff <= burst_data_in;
      if (move) begin
         burst_last_ff <= core_burst.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (shift) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // end flag rides only on the final beat of the list
   always_ff @(posedge clock) begin
      if (shift) begin
         rsp_byte_ff <= burst_data_ff[0];
         rsp_end_ff  <= burst_last_ff && (burst_count_ff == RES_CNT_W'(1));
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_byte_ff;
   assign rsp_bus.out_end  = rsp_end_ff;

endmodule

[rtl/smb_checker.sv]
// Port-level checks for the substring match bracketer, bound to the top level.
module smb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [smb_pkg::BYTE_W-1:0]     rsp_byte,
   input logic                           rsp_end,
   input logic                           csr_ready
);
   import smb_pkg::*;

   // nothing may come out straight after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // the input side is open after reset
   a_req_open_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

   // register writes are never refused
   a_csr_ready: assert property (@(posedge clock)
      disable iff (reset) csr_ready)
      else $error("register write refused");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_end))
      else $error("stalled result beat changed");

endmodule

bind substring_match_bracketer_unit smb_checker u_smb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_byte  (rsp_bus.out_byte),
   .rsp_end   (rsp_bus.out_end),
   .csr_ready (csr_bus.ready)
);
